>>> design/bis_pkg.sv
// shared types, constants and widths for the binomial inversion sampler
`default_nettype none
package bis_pkg;

   // default configuration
   localparam int MAX_TRIALS_DEF     = 1024;
   localparam int PROB_FRAC_BITS_DEF = 48;

   // field widths
   localparam int TRIALS_W = 11;
   localparam int THETA_W  = 32;
   localparam int DRAW_W   = 32;

   // datapath widths
   localparam int WORD_W   = 64;
   localparam int PROD_W   = 128;
   localparam int MANT_W   = 51;
   localparam int EXP_W    = 24;
   localparam int RATIO_W  = 52;
   localparam int RATIO_INT_W = 20;
   localparam int DIV_CNT_W = 7;
   localparam int DIV_SHIFT = 12;
   localparam int THETA_SHIFT = 32;

   // mantissa starts at 1.0 * 2^50 with exponent -50
   localparam logic [MANT_W-1:0] MANT_ONE = {1'b1, {(MANT_W-1){1'b0}}};
   localparam int MANT_EXP0 = -(MANT_W - 1);

   // conversion limits for the block-floating to fixed-point step
   localparam int CONV_SHL_MAX = 12;
   localparam int CONV_SHR_MIN = -64;

   // iteration counts of the divider
   localparam logic [DIV_CNT_W-1:0] DIV_ITER_MANT  = DIV_CNT_W'(WORD_W);
   localparam logic [DIV_CNT_W-1:0] DIV_ITER_RATIO = DIV_CNT_W'(RATIO_W);

   localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

   // multiplier command
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } mul_cmd_type;

   // divider command
   typedef struct packed {
      logic                 start;
      logic [WORD_W-1:0]    rem0;
      logic [WORD_W-1:0]    dividend;
      logic [WORD_W-1:0]    den;
      logic [DIV_CNT_W-1:0] iters;
   } div_cmd_type;

   // unit status
   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage
`default_nettype wire

>>> design/bis_req_if.sv
// request channel carrying trials, probability and uniform draw
`default_nettype none
interface bis_req_if;
   logic                          valid;
   logic                          ready;
   logic [bis_pkg::TRIALS_W-1:0]  trials;
   logic [bis_pkg::THETA_W-1:0]   success_prob;
   logic [bis_pkg::DRAW_W-1:0]    uniform_draw;

   modport source (output valid, trials, success_prob, uniform_draw, input ready);
   modport sink   (input valid, trials, success_prob, uniform_draw, output ready);
endinterface
`default_nettype wire

>>> design/bis_rsp_if.sv
// response channel carrying the sample and the parameter error flag
`default_nettype none
interface bis_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bis_pkg::TRIALS_W-1:0]  sample;
   logic                          param_error;

   modport source (output valid, sample, param_error, input ready);
   modport sink   (input valid, sample, param_error, output ready);
endinterface
`default_nettype wire

>>> design/bis_mul_unit.sv
// shared 64x64 multiplier, 16 multiplier bits per cycle
`default_nettype none
module bis_mul_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bis_pkg::mul_cmd_type          cmd,
   output bis_pkg::unit_sts_type              sts,
   output logic [bis_pkg::PROD_W-1:0]         product
);

   localparam int DIGIT_W = 16;
   localparam int PP_W    = bis_pkg::WORD_W + DIGIT_W;

   logic [bis_pkg::WORD_W-1:0] a_ff, a_in;
   logic [bis_pkg::WORD_W-1:0] b_ff, b_in;
   logic [bis_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic [1:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [PP_W-1:0]            pp;
   logic [bis_pkg::PROD_W-1:0] pp_shifted;

   // one partial product per cycle, aligned by the digit index
   always_comb begin
      pp         = PP_W'(a_ff) * PP_W'(b_ff[DIGIT_W-1:0]);
      pp_shifted = bis_pkg::PROD_W'(pp) << {cnt_ff, 4'b0000};
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         a_in    = cmd.a;
         b_in    = cmd.b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_shifted;
         b_in   = b_ff >> DIGIT_W;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operands and accumulator
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = acc_ff;

endmodule
`default_nettype wire

>>> design/bis_div_unit.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module bis_div_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bis_pkg::div_cmd_type          cmd,
   output bis_pkg::unit_sts_type              sts,
   output logic [bis_pkg::WORD_W-1:0]         quotient
);

   logic [bis_pkg::WORD_W-1:0]    rem_ff, rem_in;
   logic [bis_pkg::WORD_W-1:0]    dvd_ff, dvd_in;
   logic [bis_pkg::WORD_W-1:0]    den_ff, den_in;
   logic [bis_pkg::WORD_W-1:0]    quo_ff, quo_in;
   logic [bis_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bis_pkg::WORD_W:0]      trial;
   logic                          fits;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      trial = {rem_ff, dvd_ff[bis_pkg::WORD_W-1]};
      fits  = trial >= {1'b0, den_ff};
   end

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = cmd.rem0;
         dvd_in  = cmd.dividend;
         den_in  = cmd.den;
         quo_in  = '0;
         cnt_in  = cmd.iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? bis_pkg::WORD_W'(trial - {1'b0, den_ff})
                       : bis_pkg::WORD_W'(trial);
         quo_in = {quo_ff[bis_pkg::WORD_W-2:0], fits};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - bis_pkg::DIV_CNT_W'(1);
         if (cnt_ff == bis_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> design/binomial_inversion_sampler_top.sv
// binomial sampler by inversion from the mode, sequencer over shared multiply and divide
//
//  channel  dir  fields                                   transfer when
//  req_ch   in   trials, success_prob, uniform_draw       valid && ready
//  rsp_ch   out  sample, param_error                      valid && ready
//
// one item at a time; ready only while the sequencer is idle
// mode probability: k product terms (multiplies, a divide and a one-bit-per-cycle
//   normalize in each), plus n-2k extra multiplies
// outward walk: three multiplies and, unless the ratio saturates, a divide per point
// a bad-parameter item goes straight from idle to the finish state; results wait in an output register
// synchronous active-high reset returns the sequencer to idle, no clearing pass
`default_nettype none
module binomial_inversion_sampler_top #(
   parameter int MAX_TRIALS     = bis_pkg::MAX_TRIALS_DEF,
   parameter int PROB_FRAC_BITS = bis_pkg::PROB_FRAC_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   bis_req_if.sink   req_ch,
   bis_rsp_if.source rsp_ch
);

   localparam int PW = PROB_FRAC_BITS + 1;
   localparam int UW = PROB_FRAC_BITS;
   localparam int NW = bis_pkg::TRIALS_W;
   localparam int XW = NW + 1;
   localparam int CW = NW + 2;
   localparam int TW = bis_pkg::THETA_W;
   localparam int EW = bis_pkg::EXP_W;
   localparam int MW = bis_pkg::MANT_W;
   localparam int WW = bis_pkg::WORD_W;
   localparam int RW = bis_pkg::RATIO_W;
   localparam int RI = bis_pkg::RATIO_INT_W;
   localparam logic [PW-1:0] PROB_ONE = {1'b1, {UW{1'b0}}};

   // sequencer states
   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_MODE     = 5'd1;
   localparam logic [4:0] S_MODE_W   = 5'd2;
   localparam logic [4:0] S_PI_CHK   = 5'd3;
   localparam logic [4:0] S_PI_DIV   = 5'd4;
   localparam logic [4:0] S_PI_DW    = 5'd5;
   localparam logic [4:0] S_PI_TH    = 5'd6;
   localparam logic [4:0] S_PI_CTH   = 5'd7;
   localparam logic [4:0] S_PI_NEXT  = 5'd8;
   localparam logic [4:0] S_PC_CHK   = 5'd9;
   localparam logic [4:0] S_PC_NEXT  = 5'd10;
   localparam logic [4:0] S_MULW     = 5'd11;
   localparam logic [4:0] S_NORM     = 5'd12;
   localparam logic [4:0] S_CONV     = 5'd13;
   localparam logic [4:0] S_R_NUM    = 5'd14;
   localparam logic [4:0] S_R_NUMW   = 5'd15;
   localparam logic [4:0] S_R_DEN    = 5'd16;
   localparam logic [4:0] S_R_DENW   = 5'd17;
   localparam logic [4:0] S_R_DIV    = 5'd18;
   localparam logic [4:0] S_R_DIVW   = 5'd19;
   localparam logic [4:0] S_R_SC     = 5'd20;
   localparam logic [4:0] S_R_SCW    = 5'd21;
   localparam logic [4:0] S_INIT_PU  = 5'd22;
   localparam logic [4:0] S_LO       = 5'd23;
   localparam logic [4:0] S_LO_UPD   = 5'd24;
   localparam logic [4:0] S_HI       = 5'd25;
   localparam logic [4:0] S_HI_UPD   = 5'd26;
   localparam logic [4:0] S_FIN      = 5'd27;

   logic [4:0]              state_ff, state_in;
   logic [4:0]              ret_ff, ret_in;
   logic [NW-1:0]           n_ff, n_in;
   logic [TW-1:0]           th_ff, th_in;
   logic [TW:0]             cth_ff, cth_in;
   logic [UW-1:0]           u_ff, u_in;
   logic [NW-1:0]           mode_ff, mode_in;
   logic [XW-1:0]           i_ff, i_in;
   logic [CW-1:0]           c_ff, c_in;
   logic [MW-1:0]           m_ff, m_in;
   logic signed [EW-1:0]    e_ff, e_in;
   logic [bis_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic [PW-1:0]           pl_ff, pl_in;
   logic [PW-1:0]           pu_ff, pu_in;
   logic [PW-1:0]           p_op_ff, p_op_in;
   logic [PW-1:0]           scaled_ff, scaled_in;
   logic [XW-1:0]           na_ff, na_in;
   logic [TW:0]             nb_ff, nb_in;
   logic [XW-1:0]           da_ff, da_in;
   logic [TW:0]             db_ff, db_in;
   logic [WW-1:0]           num_ff, num_in;
   logic [WW-1:0]           den_ff, den_in;
   logic [RW-1:0]           ratio_ff, ratio_in;
   logic                    lo_valid_ff, lo_valid_in;
   logic [NW-1:0]           xl_ff, xl_in;
   logic [XW-1:0]           xu_ff, xu_in;
   logic [NW-1:0]           fin_sample_ff, fin_sample_in;
   logic                    fin_err_ff, fin_err_in;
   logic                    out_valid_ff, out_valid_in;
   logic [NW-1:0]           out_sample_ff, out_sample_in;
   logic                    out_err_ff, out_err_in;

   bis_pkg::mul_cmd_type       mul_cmd;
   bis_pkg::unit_sts_type      mul_sts;
   logic [bis_pkg::PROD_W-1:0] mul_product;
   bis_pkg::div_cmd_type       div_cmd;
   bis_pkg::unit_sts_type      div_sts;
   logic [WW-1:0]              div_quotient;

   logic [NW-1:0]        n_clamp;
   logic signed [EW-1:0] s_val;
   logic signed [EW-1:0] neg_s;
   logic [WW-1:0]        shl_val;
   logic [PW-1:0]        conv_prob;
   logic [WW-1:0]        sc_mid;
   logic [PW-1:0]        sc_val;
   logic [XW-1:0]        n_ext;
   logic [XW-1:0]        n_minus_k;
   logic                 ratio_sat;
   logic [NW-1:0]        mode_raw;

   bis_mul_unit u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .sts     (mul_sts),
      .product (mul_product)
   );

   bis_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .sts      (div_sts),
      .quotient (div_quotient)
   );

   // trial count clamp
   always_comb begin
      if (32'(req_ch.trials) > MAX_TRIALS) begin
         n_clamp = NW'(MAX_TRIALS);
      end else begin
         n_clamp = req_ch.trials;
      end
   end

   // block-floating mantissa to fixed-point probability
   always_comb begin
      s_val   = e_ff + EW'(PROB_FRAC_BITS);
      neg_s   = -s_val;
      shl_val = WW'(m_ff) << s_val[3:0];
      if (s_val > 0) begin
         if (s_val > bis_pkg::CONV_SHL_MAX) begin
            conv_prob = PROB_ONE;
         end else if (shl_val > WW'(PROB_ONE)) begin
            conv_prob = PROB_ONE;
         end else begin
            conv_prob = PW'(shl_val);
         end
      end else if (s_val <= bis_pkg::CONV_SHR_MIN) begin
         conv_prob = '0;
      end else begin
         conv_prob = PW'(WW'(m_ff) >> neg_s[5:0]);
      end
   end

   // probability times ratio, back to the probability format with saturation
   always_comb begin
      sc_mid = mul_product[WW+31:32];
      if (mul_product[bis_pkg::PROD_W-1:WW+32] != '0) begin
         sc_val = PROB_ONE;
      end else if (sc_mid > WW'(PROB_ONE)) begin
         sc_val = PROB_ONE;
      end else begin
         sc_val = PW'(sc_mid);
      end
   end

   // misc helpers
   always_comb begin
      n_ext     = {1'b0, n_ff};
      n_minus_k = n_ext - {1'b0, mode_ff};
      ratio_sat = (den_ff == '0) ||
                  ({{RI{1'b0}}, num_ff} >= {den_ff, {RI{1'b0}}});
      mode_raw  = mul_product[NW+31:32];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      n_in          = n_ff;
      th_in         = th_ff;
      cth_in        = cth_ff;
      u_in          = u_ff;
      mode_in       = mode_ff;
      i_in          = i_ff;
      c_in          = c_ff;
      m_in          = m_ff;
      e_in          = e_ff;
      acc_in        = acc_ff;
      pl_in         = pl_ff;
      pu_in         = pu_ff;
      p_op_in       = p_op_ff;
      scaled_in     = scaled_ff;
      na_in         = na_ff;
      nb_in         = nb_ff;
      da_in         = da_ff;
      db_in         = db_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      ratio_in      = ratio_ff;
      lo_valid_in   = lo_valid_ff;
      xl_in         = xl_ff;
      xu_in         = xu_ff;
      fin_sample_in = fin_sample_ff;
      fin_err_in    = fin_err_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_sample_in = out_sample_ff;
      out_err_in    = out_err_ff;
      mul_cmd       = '0;
      div_cmd       = '0;
      req_ch.ready  = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               n_in   = n_clamp;
               th_in  = req_ch.success_prob;
               cth_in = {1'b1, {TW{1'b0}}} - {1'b0, req_ch.success_prob};
               u_in   = UW'(req_ch.uniform_draw) << (UW - bis_pkg::DRAW_W);
               if (n_clamp == '0 || req_ch.success_prob == '0) begin
                  fin_sample_in = '0;
                  fin_err_in    = 1'b1;
                  state_in      = S_FIN;
               end else begin
                  state_in = S_MODE;
               end
            end
         end
         S_MODE: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a     = WW'(n_ext + XW'(1));
            mul_cmd.b     = WW'(th_ff);
            state_in      = S_MODE_W;
         end
         S_MODE_W: begin
            if (mul_sts.done) begin
               mode_in  = (mode_raw > n_ff) ? n_ff : mode_raw;
               m_in     = bis_pkg::MANT_ONE;
               e_in     = EW'(bis_pkg::MANT_EXP0);
               i_in     = XW'(1);
               state_in = S_PI_CHK;
            end
         end
         // product loop over the mode
         S_PI_CHK: begin
            if (i_ff <= {1'b0, mode_ff}) begin
               mul_cmd.start = 1'b1;
               mul_cmd.a     = WW'(m_ff);
               mul_cmd.b     = WW'(n_minus_k + i_ff);
               ret_in        = S_PI_DIV;
               state_in      = S_MULW;
            end else begin
               c_in     = {1'b0, mode_ff, 1'b0};
               state_in = S_PC_CHK;
            end
         end
         S_PI_DIV: begin
            div_cmd.start    = 1'b1;
            div_cmd.rem0     = '0;
            div_cmd.dividend = {1'b0, m_ff, {bis_pkg::DIV_SHIFT{1'b0}}};
            div_cmd.den      = WW'(i_ff);
            div_cmd.iters    = bis_pkg::DIV_ITER_MANT;
            e_in             = e_ff - EW'(bis_pkg::DIV_SHIFT);
            state_in         = S_PI_DW;
         end
         S_PI_DW: begin
            if (div_sts.done) begin
               acc_in   = bis_pkg::PROD_W'(div_quotient);
               ret_in   = S_PI_TH;
               state_in = S_NORM;
            end
         end
         S_PI_TH: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a     = WW'(m_ff);
            mul_cmd.b     = WW'(th_ff);
            e_in          = e_ff - EW'(bis_pkg::THETA_SHIFT);
            ret_in        = S_PI_CTH;
            state_in      = S_MULW;
         end
         S_PI_CTH: begin
            if (i_ff <= n_minus_k) begin
               mul_cmd.start = 1'b1;
               mul_cmd.a     = WW'(m_ff);
               mul_cmd.b     = WW'(cth_ff);
               e_in          = e_ff - EW'(bis_pkg::THETA_SHIFT);
               ret_in        = S_PI_NEXT;
               state_in      = S_MULW;
            end else begin
               state_in = S_PI_NEXT;
            end
         end
         S_PI_NEXT: begin
            i_in     = i_ff + XW'(1);
            state_in = S_PI_CHK;
         end
         // remaining 1-theta factors
         S_PC_CHK: begin
            if (c_ff < CW'(n_ff)) begin
               mul_cmd.start = 1'b1;
               mul_cmd.a     = WW'(m_ff);
               mul_cmd.b     = WW'(cth_ff);
               e_in          = e_ff - EW'(bis_pkg::THETA_SHIFT);
               ret_in        = S_PC_NEXT;
               state_in      = S_MULW;
            end else begin
               state_in = S_CONV;
            end
         end
         S_PC_NEXT: begin
            c_in     = c_ff + CW'(1);
            state_in = S_PC_CHK;
         end
         S_MULW: begin
            if (mul_sts.done) begin
               acc_in   = mul_product;
               state_in = S_NORM;
            end
         end
         // one-bit-per-cycle normalize into [2^50, 2^51)
         S_NORM: begin
            if (acc_ff[bis_pkg::PROD_W-1:MW] != '0) begin
               acc_in = acc_ff >> 1;
               e_in   = e_ff + EW'(1);
            end else if (acc_ff[MW-1:0] != '0 && !acc_ff[MW-1]) begin
               acc_in = acc_ff << 1;
               e_in   = e_ff - EW'(1);
            end else begin
               m_in     = acc_ff[MW-1:0];
               state_in = ret_ff;
            end
         end
         S_CONV: begin
            pl_in    = conv_prob;
            p_op_in  = conv_prob;
            na_in    = n_minus_k;
            nb_in    = {1'b0, th_ff};
            da_in    = {1'b0, mode_ff} + XW'(1);
            db_in    = cth_ff;
            ret_in   = S_INIT_PU;
            state_in = S_R_NUM;
         end
         // ratio and scale routine
         S_R_NUM: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a     = WW'(na_ff);
            mul_cmd.b     = WW'(nb_ff);
            state_in      = S_R_NUMW;
         end
         S_R_NUMW: begin
            if (mul_sts.done) begin
               num_in   = mul_product[WW-1:0];
               state_in = S_R_DEN;
            end
         end
         S_R_DEN: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a     = WW'(da_ff);
            mul_cmd.b     = WW'(db_ff);
            state_in      = S_R_DENW;
         end
         S_R_DENW: begin
            if (mul_sts.done) begin
               den_in   = mul_product[WW-1:0];
               state_in = S_R_DIV;
            end
         end
         S_R_DIV: begin
            if (ratio_sat) begin
               ratio_in = bis_pkg::RATIO_MAX;
               state_in = S_R_SC;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.rem0     = num_ff >> RI;
               div_cmd.dividend = {num_ff[RI-1:0], {(WW-RI){1'b0}}};
               div_cmd.den      = den_ff;
               div_cmd.iters    = bis_pkg::DIV_ITER_RATIO;
               state_in         = S_R_DIVW;
            end
         end
         S_R_DIVW: begin
            if (div_sts.done) begin
               ratio_in = div_quotient[RW-1:0];
               state_in = S_R_SC;
            end
         end
         S_R_SC: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a     = WW'(p_op_ff);
            mul_cmd.b     = WW'(ratio_ff);
            state_in      = S_R_SCW;
         end
         S_R_SCW: begin
            if (mul_sts.done) begin
               scaled_in = sc_val;
               state_in  = ret_ff;
            end
         end
         S_INIT_PU: begin
            pu_in       = scaled_ff;
            lo_valid_in = 1'b1;
            xl_in       = mode_ff;
            xu_in       = {1'b0, mode_ff} + XW'(1);
            state_in    = S_LO;
         end
         // downward step
         S_LO: begin
            if (!lo_valid_ff) begin
               state_in = S_HI;
            end else if ({1'b0, u_ff} <= pl_ff) begin
               fin_sample_in = xl_ff;
               fin_err_in    = 1'b0;
               state_in      = S_FIN;
            end else begin
               u_in = UW'({1'b0, u_ff} - pl_ff);
               if (xl_ff == '0) begin
                  lo_valid_in = 1'b0;
                  state_in    = S_HI;
               end else begin
                  p_op_in  = pl_ff;
                  na_in    = {1'b0, xl_ff};
                  nb_in    = cth_ff;
                  da_in    = n_ext + XW'(1) - {1'b0, xl_ff};
                  db_in    = {1'b0, th_ff};
                  ret_in   = S_LO_UPD;
                  state_in = S_R_NUM;
               end
            end
         end
         S_LO_UPD: begin
            pl_in    = scaled_ff;
            xl_in    = xl_ff - NW'(1);
            state_in = S_HI;
         end
         // upward step
         S_HI: begin
            if (xu_ff > n_ext) begin
               if (lo_valid_ff) begin
                  state_in = S_LO;
               end else begin
                  fin_sample_in = '0;
                  fin_err_in    = 1'b0;
                  state_in      = S_FIN;
               end
            end else if ({1'b0, u_ff} <= pu_ff) begin
               fin_sample_in = NW'(xu_ff);
               fin_err_in    = 1'b0;
               state_in      = S_FIN;
            end else begin
               u_in     = UW'({1'b0, u_ff} - pu_ff);
               p_op_in  = pu_ff;
               na_in    = n_ext - xu_ff;
               nb_in    = {1'b0, th_ff};
               da_in    = xu_ff + XW'(1);
               db_in    = cth_ff;
               ret_in   = S_HI_UPD;
               state_in = S_R_NUM;
            end
         end
         S_HI_UPD: begin
            pu_in    = scaled_ff;
            xu_in    = xu_ff + XW'(1);
            state_in = S_LO;
         end
         // hand the result to the output register
         S_FIN: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in  = 1'b1;
               out_sample_in = fin_sample_ff;
               out_err_in    = fin_err_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      n_ff          <= n_in;
      th_ff         <= th_in;
      cth_ff        <= cth_in;
      u_ff          <= u_in;
      mode_ff       <= mode_in;
      i_ff          <= i_in;
      c_ff          <= c_in;
      m_ff          <= m_in;
      e_ff          <= e_in;
      acc_ff        <= acc_in;
      pl_ff         <= pl_in;
      pu_ff         <= pu_in;
      p_op_ff       <= p_op_in;
      scaled_ff     <= scaled_in;
      na_ff         <= na_in;
      nb_ff         <= nb_in;
      da_ff         <= da_in;
      db_ff         <= db_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      ratio_ff      <= ratio_in;
      lo_valid_ff   <= lo_valid_in;
      xl_ff         <= xl_in;
      xu_ff         <= xu_in;
      fin_sample_ff <= fin_sample_in;
      fin_err_ff    <= fin_err_in;
      out_sample_ff <= out_sample_in;
      out_err_ff    <= out_err_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.sample      = out_sample_ff;
   assign rsp_ch.param_error = out_err_ff;

   // shared units are only started when free
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_cmd.start |-> !mul_sts.busy)
      else $error("multiplier started while busy");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_sts.busy)
      else $error("divider started while busy");

   // upward index never runs past n+1 during the walk
   a_xu_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HI) |-> (xu_ff <= n_ext + XW'(1)))
      else $error("upward index out of range");

   // an accepted item either starts the mode search or reports a bad parameter
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == S_MODE || state_ff == S_FIN))
      else $error("unexpected state after request transfer");

endmodule
`default_nettype wire

>>> tb/sv/tb_binomial_inversion_sampler_top.sv
// testbench for the binomial inversion sampler: bit-exact prediction and scoreboard check
`default_nettype none
module tb_binomial_inversion_sampler_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM = 300;
   localparam int IDLE_LIMIT = 2000000;
   localparam logic [63:0] PROB_ONE = 64'd1 << bis_pkg::PROB_FRAC_BITS_DEF;
   localparam logic [63:0] MANT_LO  = 64'd1 << 50;
   localparam logic [63:0] MANT_HI  = 64'd1 << 51;
   localparam logic [63:0] RMAX     = (64'd1 << 52) - 64'd1;

   typedef struct packed {
      logic [bis_pkg::TRIALS_W-1:0] trials;
      logic [bis_pkg::THETA_W-1:0]  success_prob;
      logic [bis_pkg::DRAW_W-1:0]   uniform_draw;
   } draw_item_type;

   typedef struct packed {
      logic [bis_pkg::TRIALS_W-1:0] sample;
      logic                         param_error;
   } sample_item_type;

   logic clock, reset;
   bis_req_if req_ch ();
   bis_rsp_if rsp_ch ();

   binomial_inversion_sampler_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   draw_item_type   pending_draws[$];
   sample_item_type expected_samples[$];
   int  error_count = 0;
   bit  stimulus_done = 0;
   bit  quiet_tail = 0;
   int  idle_cycles = 0;
   int  send_gap = 0;
   int  recv_gap = 0;

   // block-floating mantissa and exponent
   logic [63:0] bf_mant;
   int          bf_exp;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
   endtask

   function automatic void bf_normalize(input logic [127:0] prod);
      while (prod >= {64'd0, MANT_HI}) begin
         prod = prod >> 1;
         bf_exp++;
      end
      while (prod != 0 && prod < {64'd0, MANT_LO}) begin
         prod = prod << 1;
         bf_exp--;
      end
      bf_mant = prod[63:0];
   endfunction

   function automatic void bf_scale(input logic [63:0] factor, input int fshift);
      logic [127:0] prod;
      prod = {64'd0, bf_mant} * {64'd0, factor};
      bf_exp += fshift;
      bf_normalize(prod);
   endfunction

   function automatic void bf_divide(input logic [63:0] d);
      logic [63:0] shifted;
      if (d == 0) return;
      shifted = bf_mant << 12;
      bf_exp -= 12;
      bf_normalize({64'd0, shifted / d});
   endfunction

   function automatic logic [63:0] mode_probability(input logic [63:0] k, input logic [63:0] n,
                                                    input logic [63:0] th, input logic [63:0] cth);
      logic [63:0] i, r;
      int s;
      bf_mant = MANT_LO;
      bf_exp  = -50;
      for (i = 1; i <= k; i++) begin
         bf_scale(n - k + i, 0);
         bf_divide(i);
         bf_scale(th, -32);
         if (i <= n - k) bf_scale(cth, -32);
      end
      for (i = 2 * k; i < n; i++) bf_scale(cth, -32);
      s = bf_exp + bis_pkg::PROB_FRAC_BITS_DEF;
      if (s > 0) begin
         if (s > 12) return PROB_ONE;
         r = bf_mant << s;
         return (r > PROB_ONE) ? PROB_ONE : r;
      end
      if (s <= -64) return 64'd0;
      return bf_mant >> (-s);
   endfunction

   // floor(num * 2^32 / den) in Q20.32, saturating
   function automatic logic [63:0] step_ratio(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      if (den == 0) return RMAX;
      q = num / den;
      if (q >= (64'd1 << 20)) return RMAX;
      return 64'(({64'd0, num} << 32) / {64'd0, den});
   endfunction

   function automatic logic [63:0] apply_ratio(input logic [63:0] p, input logic [63:0] ratio);
      logic [127:0] prod;
      logic [63:0]  r;
      prod = {64'd0, p} * {64'd0, ratio};
      if (prod[127:96] != 0) return PROB_ONE;
      r = prod[95:32];
      return (r > PROB_ONE) ? PROB_ONE : r;
   endfunction

   function automatic sample_item_type predict_sample(input draw_item_type it);
      sample_item_type res;
      logic [63:0] n, th, u, cth, mode, pl, pu, xu, x;
      longint xl;
      res = '0;
      n  = 64'(it.trials);
      th = 64'(it.success_prob);
      u  = 64'(it.uniform_draw) << (bis_pkg::PROB_FRAC_BITS_DEF - 32);
      if (n > bis_pkg::MAX_TRIALS_DEF) n = bis_pkg::MAX_TRIALS_DEF;
      if (n == 0 || th == 0) begin
         res.param_error = 1'b1;
         return res;
      end
      cth  = (64'd1 << 32) - th;
      mode = (th * (n + 1)) >> 32;
      if (mode > n) mode = n;
      pl = mode_probability(mode, n, th, cth);
      pu = apply_ratio(pl, step_ratio((n - mode) * th, (mode + 1) * cth));
      xl = longint'(mode);
      xu = mode + 1;
      while (xl >= 0 || xu <= n) begin
         if (xl >= 0) begin
            x = 64'(xl);
            if (u <= pl) begin
               res.sample = x[bis_pkg::TRIALS_W-1:0];
               return res;
            end
            u -= pl;
            pl = apply_ratio(pl, step_ratio(x * cth, (n + 1 - x) * th));
            xl--;
         end
         if (xu <= n) begin
            if (u <= pu) begin
               res.sample = xu[bis_pkg::TRIALS_W-1:0];
               return res;
            end
            u -= pu;
            pu = apply_ratio(pu, step_ratio((n - xu) * th, (xu + 1) * cth));
            xu++;
         end
      end
      return res;
   endfunction

   function automatic draw_item_type make_draw(input int n, input logic [31:0] th,
                                               input logic [31:0] u);
      draw_item_type it;
      it.trials       = bis_pkg::TRIALS_W'(n);
      it.success_prob = th;
      it.uniform_draw = u;
      return it;
   endfunction

   // stimulus: directed corners, then random draws with mostly small n
   initial begin
      int n, sel;
      logic [31:0] th;
      pending_draws.push_back(make_draw(0, 32'h8000_0000, 32'h1234_5678));
      pending_draws.push_back(make_draw(10, 32'h0, 32'h1234_5678));
      pending_draws.push_back(make_draw(0, 32'h0, 32'hFFFF_FFFF));
      pending_draws.push_back(make_draw(1, 32'h8000_0000, 32'h0));
      pending_draws.push_back(make_draw(1, 32'h8000_0000, 32'hFFFF_FFFF));
      pending_draws.push_back(make_draw(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
      pending_draws.push_back(make_draw(1, 32'h0000_0001, 32'hFFFF_FFFF));
      pending_draws.push_back(make_draw(20, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_draws.push_back(make_draw(20, 32'h0000_0001, 32'hFFFF_FFFF));
      pending_draws.push_back(make_draw(16, 32'h4000_0000, 32'hFFFF_FFFF));
      pending_draws.push_back(make_draw(16, 32'h4000_0000, 32'h0));
      pending_draws.push_back(make_draw(1024, 32'h8000_0000, 32'h8000_0000));
      pending_draws.push_back(make_draw(2047, 32'h5555_5555, 32'hAAAA_AAAA));
      pending_draws.push_back(make_draw(1025, 32'h1000_0000, 32'hFFFF_FFFF));
      pending_draws.push_back(make_draw(1024, 32'hFFFF_FFFF, 32'h0000_0001));
      pending_draws.push_back(make_draw(7, 32'hAAAA_AAAA, 32'h5555_5555));
      for (int i = 0; i < NUM_RANDOM; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 3)        n = 0;
         else if (sel < 6)   n = $urandom_range(1025, 2047);
         else if (sel < 10)  n = $urandom_range(200, 1024);
         else                n = $urandom_range(1, 40);
         sel = $urandom_range(0, 19);
         if (sel == 0)      th = 32'h0;
         else if (sel == 1) th = $urandom_range(1, 255);
         else if (sel == 2) th = 32'hFFFF_FFFF - $urandom_range(0, 255);
         else               th = $urandom;
         pending_draws.push_back(make_draw(n, th, $urandom));
      end
   end

   // reset
   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // request driver
   initial begin
      req_ch.valid = 1'b0;
      req_ch.trials = '0;
      req_ch.success_prob = '0;
      req_ch.uniform_draw = '0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            expected_samples.push_back(predict_sample(
               make_draw(req_ch.trials, req_ch.success_prob, req_ch.uniform_draw)));
            pending_draws.pop_front();
            quiet_tail <= (pending_draws.size() < 30);
            if (!quiet_tail && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 16);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_draws.size() > 0) begin
            req_ch.valid        <= 1'b1;
            req_ch.trials       <= pending_draws[0].trials;
            req_ch.success_prob <= pending_draws[0].success_prob;
            req_ch.uniform_draw <= pending_draws[0].uniform_draw;
         end else begin
            req_ch.valid  <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // response monitor with random stalls
   initial rsp_ch.ready = 1'b0;

   always @(posedge clock) begin
      sample_item_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer sample=%0d err=%0b",
                                         rsp_ch.sample, rsp_ch.param_error));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_ch.sample !== want.sample)
                  report_mismatch($sformatf("sample got %0d want %0d",
                                            rsp_ch.sample, want.sample));
               if (rsp_ch.param_error !== want.param_error)
                  report_mismatch($sformatf("param_error got %0b want %0b",
                                            rsp_ch.param_error, want.param_error));
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 15);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // end of run
   initial begin
      wait (stimulus_done && expected_samples.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
